// ===== rtl/core/klq_pkg.sv =====
// ----------------------------------------------------------------------------
// KeeLoq cipher package
// Shared constants, item type and round functions for the cipher cell chain.
// ----------------------------------------------------------------------------
package klq_pkg;

	localparam int ROUNDS          = 528;
	localparam int ROUNDS_PER_CELL = 4;
	localparam int NUM_CELLS       = ROUNDS / ROUNDS_PER_CELL;

	localparam logic [31:0] NLF_TABLE     = 32'h3A5C742E;
	localparam logic [31:0] LOW28_MASK    = 32'h0FFFFFFF;
	localparam logic [31:0] NIBBLE_FIRST  = 32'h20000000;
	localparam logic [31:0] NIBBLE_SECOND = 32'h60000000;
	localparam int          KEY_BIT_MASK  = 63;

	localparam logic [1:0] OP_ENCRYPT = 2'd0;
	localparam logic [1:0] OP_DECRYPT = 2'd1;
	localparam logic [1:0] OP_DERIVE  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] lane_a;
		logic [31:0] lane_b;
	} klq_item_t;

	function automatic logic [5:0] enc_key_idx(input int r);
		return 6'(r & KEY_BIT_MASK);
	endfunction

	function automatic logic [5:0] dec_key_idx(input int r);
		return 6'((15 - r) & KEY_BIT_MASK);
	endfunction

	function automatic logic [31:0] enc_round(input logic [31:0] x, input logic k);
		logic fb;
		fb = x[0] ^ x[16] ^ k ^ NLF_TABLE[{x[31], x[26], x[20], x[9], x[1]}];
		return {fb, x[31:1]};
	endfunction

	function automatic logic [31:0] dec_round(input logic [31:0] x, input logic k);
		logic fb;
		fb = x[31] ^ x[15] ^ k ^ NLF_TABLE[{x[30], x[25], x[19], x[8], x[0]}];
		return {x[30:0], fb};
	endfunction

endpackage

// ===== rtl/core/klq_if.sv =====
// ----------------------------------------------------------------------------
// KeeLoq cipher channel interfaces
// Valid/ready channels for requests, results and key writes.
// ----------------------------------------------------------------------------
interface klq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] data_word;

	modport source (output valid, output operation, output data_word, input ready);
	modport sink (input valid, input operation, input data_word, output ready);
endinterface

interface klq_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

interface klq_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_key;

	modport source (output valid, output cipher_key, input ready);
	modport sink (input valid, input cipher_key, output ready);
endinterface

// ===== rtl/core/klq_cell.sv =====
// ----------------------------------------------------------------------------
// KeeLoq round cell
// Applies a fixed group of NLFSR rounds to both lanes of one item per cycle while adv is high.
// ----------------------------------------------------------------------------
module klq_cell
	import klq_pkg::*;
#(
	parameter int ROUND_BASE = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [63:0] key,
	input  logic        in_valid,
	input  klq_item_t   in_item,
	output logic        out_valid,
	output klq_item_t   out_item
);

	logic      valid_q;
	klq_item_t item_q;
	klq_item_t nxt;

	always_comb begin
		nxt = in_item;
		for (int i = 0; i < ROUNDS_PER_CELL; i++) begin
			if (in_item.op == OP_ENCRYPT) begin
				nxt.lane_a = enc_round(nxt.lane_a, key[enc_key_idx(ROUND_BASE + i)]);
			end else begin
				nxt.lane_a = dec_round(nxt.lane_a, key[dec_key_idx(ROUND_BASE + i)]);
			end
			nxt.lane_b = dec_round(nxt.lane_b, key[dec_key_idx(ROUND_BASE + i)]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

// ===== rtl/core/klq_out_stage.sv =====
// ----------------------------------------------------------------------------
// KeeLoq output stage
// Forms the result of a finished item and holds it in an output register
// backed by a skid register.
// ----------------------------------------------------------------------------
module klq_out_stage
	import klq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  klq_item_t in_item,
	output logic      adv,
	klq_rsp_if.source rsp
);

	logic        out_valid_q;
	logic [63:0] out_q;
	logic        skid_valid_q;
	logic [63:0] skid_q;
	logic [63:0] res;
	logic        take;
	logic        load;

	always_comb begin
		unique case (in_item.op)
			OP_ENCRYPT, OP_DECRYPT: res = {32'd0, in_item.lane_a};
			OP_DERIVE:              res = {in_item.lane_b, in_item.lane_a};
			default:                res = 64'd0;
		endcase
	end

	assign adv  = !skid_valid_q;
	assign take = out_valid_q && rsp.ready;
	assign load = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (load) begin
			if (!out_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.result = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while the output register is empty");

	a_blocked_goes_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_valid_q && !rsp.ready) |=> skid_valid_q)
		else $error("item arriving at a stalled output was not kept in the skid register");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !take) |=> (skid_valid_q && $stable(skid_q)))
		else $error("skid register changed while the output was stalled");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_valid_q && take && !in_valid) |=> !out_valid_q)
		else $error("output register stayed valid after its item was taken");

endmodule

// ===== rtl/core/keeloq_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// KeeLoq cipher unit
// Encrypts, decrypts or derives a normal-learning key from a 32-bit word.
// ----------------------------------------------------------------------------
// The 528 rounds run through a chain of 132 cells of four rounds each, so an
// item passes through the 132 cell registers and then the output register,
// and a new item is accepted every cycle while the skid register is empty.
// The two decrypts of a key derivation run side by side in two lanes of the
// same cells. The request channel is ready whenever the skid register behind
// the output is empty, so one result may wait unread without stopping the
// chain. The key must be written only while no item is in flight.
module keeloq_cipher_unit
	import klq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	klq_cfg_if.sink   cfg,
	klq_req_if.sink   req,
	klq_rsp_if.source rsp
);

	logic [63:0] key_q;
	logic        adv;
	logic        vld [NUM_CELLS + 1];
	klq_item_t   item [NUM_CELLS + 1];
	logic [31:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= 64'd0;
		end else if (cfg.valid && cfg.ready) begin
			key_q <= cfg.cipher_key;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = adv;

	assign base           = req.data_word & LOW28_MASK;
	assign vld[0]         = req.valid;
	assign item[0].op     = req.operation;
	assign item[0].lane_a = (req.operation == OP_DERIVE) ? (base | NIBBLE_FIRST)
	                                                     : req.data_word;
	assign item[0].lane_b = base | NIBBLE_SECOND;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		klq_cell #(
			.ROUND_BASE(c * ROUNDS_PER_CELL)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.key      (key_q),
			.in_valid (vld[c]),
			.in_item  (item[c]),
			.out_valid(vld[c + 1]),
			.out_item (item[c + 1])
		);
	end

	klq_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(vld[NUM_CELLS]),
		.in_item (item[NUM_CELLS]),
		.adv     (adv),
		.rsp     (rsp)
	);

endmodule

// ===== tb/sv/keeloq_cipher_unit_tb.sv =====
// ----------------------------------------------------------------------------
// KeeLoq cipher unit testbench
// Sends encrypt, decrypt, key derivation and unused-operation items through
// the request channel under a series of keys. Every accepted item is scored
// by a behavioral cipher model, and each result is checked in order against
// it. Both channels idle in random bursts. The receiver also holds off for one
// long stretch so the round chain fills and stalls its input.
// ----------------------------------------------------------------------------
module keeloq_cipher_unit_tb;
	import klq_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 140;
	localparam int         LONG_HOLD    = 400;
	localparam int         PHASE_ITEMS  = 152;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] data_word;
	} cipher_req_t;

	logic clk = 1'b0;
	logic arst_n;

	klq_cfg_if cfg_ch ();
	klq_req_if req_ch ();
	klq_rsp_if rsp_ch ();

	keeloq_cipher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cipher_req_t pending_reqs[$];
	logic [63:0] expected_results[$];
	logic [63:0] key_shadow = '0;
	logic [63:0] want_result;
	cipher_req_t next_req;
	logic        req_fire = 1'b0;
	logic        cfg_fire = 1'b0;
	logic        quiet_mode = 1'b0;
	int          queued_count = 0;
	int          accepted_count = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          hold_armed = 0;
	int          hold_taken = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] encrypt_word(input logic [31:0] plain, input logic [63:0] key);
		logic [31:0] x;
		logic        fb;
		int          r;
		x = plain;
		for (r = 0; r < ROUNDS; r++) begin
			fb = x[0] ^ x[16] ^ key[6'(r & 63)] ^
				NLF_TABLE[{x[31], x[26], x[20], x[9], x[1]}];
			x  = {fb, x[31:1]};
		end
		return x;
	endfunction

	function automatic logic [31:0] decrypt_word(input logic [31:0] cipher, input logic [63:0] key);
		logic [31:0] x;
		logic        fb;
		int          r;
		x = cipher;
		for (r = 0; r < ROUNDS; r++) begin
			fb = x[31] ^ x[15] ^ key[6'((15 - r) & 63)] ^
				NLF_TABLE[{x[30], x[25], x[19], x[8], x[0]}];
			x  = {x[30:0], fb};
		end
		return x;
	endfunction

	function automatic logic [63:0] predict_result(input logic [1:0] op, input logic [31:0] word,
			input logic [63:0] key);
		logic [31:0] serial;
		serial = word & LOW28_MASK;
		case (op)
			OP_ENCRYPT: return {32'h0, encrypt_word(word, key)};
			OP_DECRYPT: return {32'h0, decrypt_word(word, key)};
			OP_DERIVE: return {decrypt_word(serial | NIBBLE_SECOND, key),
				decrypt_word(serial | NIBBLE_FIRST, key)};
			default: return 64'h0;
		endcase
	endfunction

	function automatic cipher_req_t random_req();
		cipher_req_t item;
		int          pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) item.operation = OP_UNUSED;
		else if (pick < 6) item.operation = OP_ENCRYPT;
		else if (pick < 11) item.operation = OP_DECRYPT;
		else item.operation = OP_DERIVE;
		case ($urandom_range(0, 7))
			0: item.data_word = 32'h0;
			1: item.data_word = 32'hFFFF_FFFF;
			2: item.data_word = 32'd1 << $urandom_range(0, 31);
			3: item.data_word = ~(32'd1 << $urandom_range(0, 31));
			4: item.data_word = $urandom & LOW28_MASK;
			default: item.data_word = $urandom;
		endcase
		return item;
	endfunction

	task automatic queue_req(input logic [1:0] op, input logic [31:0] word);
		cipher_req_t item;
		item.operation = op;
		item.data_word = word;
		pending_reqs = {pending_reqs, item};
		queued_count++;
	endtask

	task automatic queue_random_reqs(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			pending_reqs = {pending_reqs, random_req()};
			queued_count++;
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (accepted_count != queued_count || expected_results.size() != 0);
	endtask

	task automatic load_cipher_key(input logic [63:0] key);
		wait_idle();
		cfg_ch.cipher_key <= key;
		cfg_ch.valid      <= 1'b1;
		do @(negedge clk);
		while (!cfg_fire);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (!req_ch.valid || req_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				next_req = pending_reqs.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.operation <= next_req.operation;
				req_ch.data_word <= next_req.data_word;
				if (!quiet_mode && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_taken != hold_armed) begin
			hold_taken = hold_armed;
			hold_left  = LONG_HOLD - 1;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!quiet_mode && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_fire = 1'b0;
			cfg_fire = 1'b0;
		end else begin
			req_fire = req_ch.valid && req_ch.ready;
			cfg_fire = cfg_ch.valid && cfg_ch.ready;
			if (cfg_fire) key_shadow = cfg_ch.cipher_key;
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result: expected none, actual %h", rsp_ch.result);
					fail_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (rsp_ch.result !== want_result) begin
						$error("result: expected %h, actual %h", want_result, rsp_ch.result);
						fail_count++;
					end
				end
			end
			if (req_fire) begin
				expected_results = {expected_results,
					predict_result(req_ch.operation, req_ch.data_word, key_shadow)};
				accepted_count++;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [31:0] corner_words[5];
		logic [1:0]  all_ops[4];
		int          i;
		int          j;
		corner_words = '{32'h0, 32'hFFFF_FFFF, 32'h0FFF_FFFF, 32'hF000_0000, 32'hA5A5_A5A5};
		all_ops      = '{OP_ENCRYPT, OP_DECRYPT, OP_DERIVE, OP_UNUSED};
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_ENCRYPT;
		req_ch.data_word  = 32'h0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.cipher_key = 64'h0;
		rsp_ch.ready      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The first items run under the key left by reset.
		for (i = 0; i < 4; i++)
			for (j = 0; j < 5; j++)
				queue_req(all_ops[i], corner_words[j]);

		load_cipher_key(64'h5CEC_6701_B79F_D949);
		queue_req(OP_ENCRYPT, 32'hF741_E2DB);
		queue_req(OP_DECRYPT, 32'hE44F_4CDF);
		queue_random_reqs(PHASE_ITEMS);

		load_cipher_key(64'hFFFF_FFFF_FFFF_FFFF);
		queue_random_reqs(PHASE_ITEMS);

		load_cipher_key(64'h0);
		queue_random_reqs(PHASE_ITEMS);

		load_cipher_key({$urandom, $urandom});
		hold_armed++;
		queue_random_reqs(PHASE_ITEMS + 60);

		load_cipher_key(64'h8000_0000_0000_0001);
		queue_random_reqs(PHASE_ITEMS);

		load_cipher_key({$urandom, $urandom});
		queue_random_reqs(PHASE_ITEMS);

		load_cipher_key({$urandom, $urandom});
		queue_random_reqs(PHASE_ITEMS);

		load_cipher_key({$urandom, $urandom});
		quiet_mode = 1'b1;
		queue_random_reqs(PHASE_ITEMS);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/klq_pkg.sv
rtl/core/klq_if.sv
rtl/core/klq_cell.sv
rtl/core/klq_out_stage.sv
rtl/core/keeloq_cipher_unit.sv
tb/sv/keeloq_cipher_unit_tb.sv
